@@ hdl/ngate_pkg.sv @@
// ----------------------------------------------------------------------------
// ngate_pkg: shared types and constants of the hysteresis noise gate
// Widths, number formats, register codes and reset values used by every file.
// ----------------------------------------------------------------------------
package ngate_pkg;

  localparam int SAMPLE_W  = 24;  // Q1.23 samples
  localparam int COEF_W    = 24;  // Q0.24 coefficients
  localparam int STATE_W   = 32;  // Q3.29 filter and envelope state
  localparam int XS_W      = 30;  // sidechain widened to Q1.29
  localparam int GAIN_W    = 25;  // Q1.24 gain, 0 .. 2^24
  localparam int DIFF_W    = 33;  // signed difference of two state words
  localparam int MAG_W     = 32;  // magnitude of such a difference
  localparam int FRAC_W    = 24;
  localparam int PROD_W    = COEF_W + MAG_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam int XS_SHIFT = XS_W - SAMPLE_W;

  localparam logic signed [STATE_W-1:0] THRESH_OPEN  = 32'sd536871;
  localparam logic signed [STATE_W-1:0] THRESH_CLOSE = 32'sd241592;
  localparam logic [GAIN_W-1:0]         GAIN_ONE     = 25'd16777216;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HP_COEF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LP_COEF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_RATE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_RATE  = 3'd6;

  localparam logic [COEF_W-1:0] RST_HP_COEF    = 24'd218000;
  localparam logic [COEF_W-1:0] RST_LP_COEF    = 24'd4883000;
  localparam logic [COEF_W-1:0] RST_ATTACK     = 24'd226000;
  localparam logic [COEF_W-1:0] RST_RELEASE    = 24'd1590;
  localparam logic [COEF_W-1:0] RST_OPEN_RATE  = 24'd338000;
  localparam logic [COEF_W-1:0] RST_CLOSE_RATE = 24'd1940;

  typedef struct packed {
    logic              gate_enable;
    logic [COEF_W-1:0] highpass_coef;
    logic [COEF_W-1:0] lowpass_coef;
    logic [COEF_W-1:0] env_attack_coef;
    logic [COEF_W-1:0] env_release_coef;
    logic [COEF_W-1:0] gain_open_rate;
    logic [COEF_W-1:0] gain_close_rate;
  } cfg_t;

  // one operation handed to the shared step unit
  typedef struct packed {
    logic              load;     // capture operands this cycle
    logic [COEF_W-1:0] coef;
    logic [MAG_W-1:0]  mag;
    logic              neg;      // step is subtracted from the base
    logic              nearest;  // round to nearest instead of up
  } step_op_t;

endpackage

@@ hdl/ngate_if.sv @@
// ----------------------------------------------------------------------------
// ngate_if: channel interfaces of the noise gate
// Input sample beats, result beats and configuration write beats.
// ----------------------------------------------------------------------------
interface ngate_in_if import ngate_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sidechain_sample;
  logic signed [SAMPLE_W-1:0] audio_sample;

  modport source (output valid, output sidechain_sample, output audio_sample, input ready);
  modport sink   (input valid, input sidechain_sample, input audio_sample, output ready);
endinterface

interface ngate_out_if import ngate_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] gated_sample;
  logic                       gate_is_open;

  modport source (output valid, output gated_sample, output gate_is_open, input ready);
  modport sink   (input valid, input gated_sample, input gate_is_open, output ready);
endinterface

interface ngate_cfg_if import ngate_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/ngate_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ngate_cfg_regs: configuration register file
// Takes write beats at any time and holds the gate's coefficients.
// ----------------------------------------------------------------------------
module ngate_cfg_regs import ngate_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ngate_cfg_if.sink  cfg_chan,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  assign cfg_chan.ready = 1'b1;
  assign cfg            = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gate_enable      <= 1'b1;
      cfg_r.highpass_coef    <= RST_HP_COEF;
      cfg_r.lowpass_coef     <= RST_LP_COEF;
      cfg_r.env_attack_coef  <= RST_ATTACK;
      cfg_r.env_release_coef <= RST_RELEASE;
      cfg_r.gain_open_rate   <= RST_OPEN_RATE;
      cfg_r.gain_close_rate  <= RST_CLOSE_RATE;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_GATE_ENABLE: cfg_r.gate_enable      <= cfg_chan.data[0];
        CFG_HP_COEF:     cfg_r.highpass_coef    <= cfg_chan.data;
        CFG_LP_COEF:     cfg_r.lowpass_coef     <= cfg_chan.data;
        CFG_ATTACK:      cfg_r.env_attack_coef  <= cfg_chan.data;
        CFG_RELEASE:     cfg_r.env_release_coef <= cfg_chan.data;
        CFG_OPEN_RATE:   cfg_r.gain_open_rate   <= cfg_chan.data;
        CFG_CLOSE_RATE:  cfg_r.gain_close_rate  <= cfg_chan.data;
        default: ;  // drop writes beyond the list
      endcase
    end
  end

endmodule

@@ hdl/ngate_step_unit.sv @@
// ----------------------------------------------------------------------------
// ngate_step_unit: shared multiply and step-apply unit
// Captures coef and magnitude, multiplies in the next cycle, then adds the
// rounded, signed step to a base word in a single adder with carry-in.
// ----------------------------------------------------------------------------
module ngate_step_unit import ngate_pkg::*; (
  input  logic                     clk,
  input  step_op_t                 op,
  input  logic signed [DIFF_W-1:0] base,
  output logic signed [DIFF_W-1:0] res
);

  logic [COEF_W-1:0] coef_r;
  logic [MAG_W-1:0]  mag_r;
  logic              neg_r;
  logic              near_r;
  logic [PROD_W-1:0] prod_r;

  logic [MAG_W-1:0]  hi;
  logic              inc;
  logic [DIFF_W-1:0] addend;
  logic              cin;

  always_ff @(posedge clk) begin
    if (op.load) begin
      coef_r <= op.coef;
      mag_r  <= op.mag;
      neg_r  <= op.neg;
      near_r <= op.nearest;
    end
    prod_r <= PROD_W'(coef_r) * PROD_W'(mag_r);
  end

  // base - (hi + inc) = base + ~hi + !inc, so the sign folds into the carry
  always_comb begin
    hi     = prod_r[PROD_W-1:FRAC_W];
    inc    = near_r ? prod_r[FRAC_W-1] : |prod_r[FRAC_W-1:0];
    addend = neg_r ? ~{1'b0, hi} : {1'b0, hi};
    cin    = neg_r ^ inc;
    res    = base + signed'(addend) + signed'(DIFF_W'(cin));
  end

endmodule

@@ hdl/hysteresis_noise_gate.sv @@
// ----------------------------------------------------------------------------
// hysteresis_noise_gate: noise gate with hysteresis detector, top level
// Sidechain high-pass and low-pass, envelope follower, hysteresis flag and
// smoothed gain, all through one shared 24 x 32 multiplier step unit.
//
//   channel   dir  beat carries                         handshake
//   in_chan   in   sidechain_sample, audio_sample       valid / ready
//   out_chan  out  gated_sample, gate_is_open           valid / ready
//   cfg_chan  in   index (0..6), data                   valid / ready (always 1)
//
// An enabled sample runs from its input beat to its result beat through five
// passes of the shared step unit (high-pass, low-pass, envelope, gain, output
// scale), each a DIF, MUL and UPD (or RND) state, plus the bookkeeping states
// HP_OUT, ENV_ABS and FLAG. A bypassed sample (gate disabled) goes through S_BYP.
// in_chan is ready only when the sequencer is idle. A result waits in the output
// register; the next sample runs meanwhile and stalls only in its final state.
// Reset is synchronous, active low, and clears all detector and gain state.
// ----------------------------------------------------------------------------
module hysteresis_noise_gate import ngate_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ngate_in_if.sink   in_chan,
  ngate_out_if.source out_chan,
  ngate_cfg_if.sink  cfg_chan
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_HP_DIF, S_HP_MUL, S_HP_UPD, S_HP_OUT,
    S_LP_DIF, S_LP_MUL, S_LP_UPD,
    S_ENV_ABS, S_ENV_DIF, S_ENV_MUL, S_ENV_UPD,
    S_FLAG,
    S_GN_DIF, S_GN_MUL, S_GN_UPD,
    S_OUT_DIF, S_OUT_MUL, S_OUT_RND,
    S_BYP
  } state_t;

  cfg_t cfg;

  state_t                     state_r;
  logic signed [XS_W-1:0]     x_r;       // sidechain in Q1.29
  logic signed [SAMPLE_W-1:0] audio_r;
  logic signed [STATE_W-1:0]  hm_r;      // high-pass memory
  logic signed [STATE_W-1:0]  lm_r;      // low-pass memory
  logic signed [STATE_W-1:0]  env_r;     // envelope level
  logic signed [DIFF_W-1:0]   hp_r;      // high-pass output
  logic [XS_W:0]              sc_mag_r;  // magnitude of the filtered sidechain
  logic                       open_r;
  logic [GAIN_W-1:0]          gain_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] gated_r;
  logic                       flag_out_r;

  logic signed [DIFF_W-1:0]   opa, opb, sub_ab, sub_ba;
  logic                       diff_neg;
  logic [MAG_W-1:0]           diff_mag;
  step_op_t                   op;
  logic signed [DIFF_W-1:0]   base, res;
  logic                       out_free;
  logic                       out_load;

  ngate_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  ngate_step_unit u_step (
    .clk  (clk),
    .op   (op),
    .base (base),
    .res  (res)
  );

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.gated_sample = gated_r;
  assign out_chan.gate_is_open = flag_out_r;
  assign out_free              = !out_valid_r || out_chan.ready;
  // a finished sample lands in the output register this cycle
  assign out_load              = ((state_r == S_OUT_RND) || (state_r == S_BYP)) && out_free;

  // Operand select for the shared subtractor pair: one gives the signed
  // difference, the other its negation, so the magnitude needs no extra adder.
  always_comb begin
    opa = '0;
    opb = '0;
    case (state_r)
      S_HP_DIF, S_HP_OUT: begin
        opa = DIFF_W'(x_r);
        opb = DIFF_W'(hm_r);
      end
      S_LP_DIF: begin
        opa = hp_r;
        opb = DIFF_W'(lm_r);
      end
      S_ENV_ABS: begin
        opb = DIFF_W'(lm_r);
      end
      S_ENV_DIF: begin
        opa = signed'(DIFF_W'(sc_mag_r));
        opb = DIFF_W'(env_r);
      end
      S_GN_DIF: begin
        opa = open_r ? signed'(DIFF_W'(GAIN_ONE)) : '0;
        opb = signed'(DIFF_W'(gain_r));
      end
      S_OUT_DIF: begin
        opa = DIFF_W'(audio_r);
      end
      default: ;
    endcase
    sub_ab   = opa - opb;
    sub_ba   = opb - opa;
    diff_neg = sub_ab[DIFF_W-1];
    diff_mag = diff_neg ? sub_ba[MAG_W-1:0] : sub_ab[MAG_W-1:0];
  end

  // Issue to the step unit and pick the word the step lands on.
  always_comb begin
    op         = '0;
    op.mag     = diff_mag;
    op.neg     = diff_neg;
    base       = '0;
    case (state_r)
      S_HP_DIF: begin
        op.load = 1'b1;
        op.coef = cfg.highpass_coef;
      end
      S_LP_DIF: begin
        op.load = 1'b1;
        op.coef = cfg.lowpass_coef;
      end
      S_ENV_DIF: begin
        // fall when below the envelope, rise otherwise (equal gives no step)
        op.load = 1'b1;
        op.coef = diff_neg ? cfg.env_release_coef : cfg.env_attack_coef;
      end
      S_GN_DIF: begin
        op.load = 1'b1;
        op.coef = diff_neg ? cfg.gain_close_rate : cfg.gain_open_rate;
      end
      S_OUT_DIF: begin
        // audio magnitude rides in the coef slot, gain in the wide slot
        op.load    = 1'b1;
        op.coef    = diff_mag[COEF_W-1:0];
        op.mag     = MAG_W'(gain_r);
        op.nearest = 1'b1;
      end
      S_HP_UPD:  base = DIFF_W'(hm_r);
      S_LP_UPD:  base = DIFF_W'(lm_r);
      S_ENV_UPD: base = DIFF_W'(env_r);
      S_GN_UPD:  base = signed'(DIFF_W'(gain_r));
      default: ;
    endcase
  end

  // Sequencer: state, detector state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hm_r        <= '0;
      lm_r        <= '0;
      env_r       <= '0;
      open_r      <= 1'b0;
      gain_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a new result beat, or retire a taken one
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            x_r     <= signed'({in_chan.sidechain_sample, XS_SHIFT'(0)});
            audio_r <= in_chan.audio_sample;
            state_r <= cfg.gate_enable ? S_HP_DIF : S_BYP;
          end
        end
        S_HP_DIF:  state_r <= S_HP_MUL;
        S_HP_MUL:  state_r <= S_HP_UPD;
        S_HP_UPD: begin
          hm_r    <= res[STATE_W-1:0];
          state_r <= S_HP_OUT;
        end
        S_HP_OUT: begin
          hp_r    <= sub_ab;
          state_r <= S_LP_DIF;
        end
        S_LP_DIF:  state_r <= S_LP_MUL;
        S_LP_MUL:  state_r <= S_LP_UPD;
        S_LP_UPD: begin
          lm_r    <= res[STATE_W-1:0];
          state_r <= S_ENV_ABS;
        end
        S_ENV_ABS: begin
          sc_mag_r <= diff_mag[XS_W:0];
          state_r  <= S_ENV_DIF;
        end
        S_ENV_DIF: state_r <= S_ENV_MUL;
        S_ENV_MUL: state_r <= S_ENV_UPD;
        S_ENV_UPD: begin
          env_r   <= res[STATE_W-1:0];
          state_r <= S_FLAG;
        end
        S_FLAG: begin
          // closed: only the open test applies; open: only the close test
          if (!open_r) begin
            if (env_r >= THRESH_OPEN) begin
              open_r <= 1'b1;
            end
          end else if (env_r < THRESH_CLOSE) begin
            open_r <= 1'b0;
          end
          state_r <= S_GN_DIF;
        end
        S_GN_DIF:  state_r <= S_GN_MUL;
        S_GN_MUL:  state_r <= S_GN_UPD;
        S_GN_UPD: begin
          gain_r  <= res[GAIN_W-1:0];
          state_r <= S_OUT_DIF;
        end
        S_OUT_DIF: state_r <= S_OUT_MUL;
        S_OUT_MUL: state_r <= S_OUT_RND;
        S_OUT_RND: begin
          // hold here until the output register is free
          if (out_free) begin
            gated_r     <= res[SAMPLE_W-1:0];
            flag_out_r  <= open_r;
            state_r     <= S_IDLE;
          end
        end
        S_BYP: begin
          // gate disabled: pass audio, report the held flag
          if (out_free) begin
            gated_r     <= audio_r;
            flag_out_r  <= open_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
